// ----- hdl/ccr_pkg.sv -----
// Shared types and constants for the clock replacement cache.
// No dependencies; used by ccr_scan and clock_replacement_cache.
`timescale 1ns / 1ps

package ccr_pkg;

   localparam int DEFAULT_MAX_SLOTS = 16;
   localparam int DATA_W            = 32;
   localparam int CAPACITY_W        = 5;
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

   // request kinds carried on req_tuser
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // lookup status handed from the scan unit to the sequencer
   typedef struct packed {
      logic done;
      logic hit;
   } scan_status_type;

endpackage

// ----- hdl/ccr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ccr_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ccr_scan.sv -----
// Key scan unit: walks the filled slots one per cycle through a single
// 32-bit comparator. Depends on ccr_pkg; drives the read port of the key RAM.
`timescale 1ns / 1ps

module ccr_scan #(
   parameter  int MAX_SLOTS = ccr_pkg::DEFAULT_MAX_SLOTS,
   localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [CNT_W-1:0]             limit,
   input  logic [ccr_pkg::DATA_W-1:0]   key,
   input  logic [ccr_pkg::DATA_W-1:0]   key_rdata,
   output logic                         rd_en,
   output logic [IDX_W-1:0]             rd_addr,
   output logic [IDX_W-1:0]             slot,
   output ccr_pkg::scan_status_type     status
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             issue;
   logic             match;
   logic             done;

   assign issue   = busy_ff && (rd_idx_ff < limit);
   assign rd_en   = issue;
   assign rd_addr = rd_idx_ff[IDX_W-1:0];
   assign match   = cmp_vld_ff && (key_rdata == key);
   assign done    = busy_ff && (match || (!issue && !cmp_vld_ff));

   always_comb begin
      busy_in    = busy_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      if (start) begin
         busy_in   = 1'b1;
         rd_idx_in = '0;
      end else if (busy_ff) begin
         if (done) begin
            busy_in = 1'b0;
         end else begin
            cmp_vld_in = issue;
            cmp_idx_in = rd_addr;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
   end

   assign slot        = cmp_idx_ff;
   assign status.done = done;
   assign status.hit  = match;

endmodule

// ----- hdl/clock_replacement_cache.sv -----
// Top level of the fully associative key/value cache with CLOCK replacement.
// Depends on ccr_pkg, ccr_ram (key and value stores) and ccr_scan (lookup).
`timescale 1ns / 1ps

// One request transfer is taken at a time; req_tready is high only while the
// sequencer is idle. Every request gives exactly one response transfer. The
// lookup walks the filled slots through one shared key comparator, one slot
// per cycle, reading keys and values from RAM with a registered read. A put
// that misses on a full cache then runs the clock hand, one reference bit per
// cycle, until it reaches a slot whose reference bit is clear. The response
// sits in an output register, so a new request is taken while it waits; the
// next response waits until that one is transferred. capacity (csr_wdata) is
// clamped to MAX_SLOTS and may be written only while idle; csr_ready is
// always high. The hit and access counts cover gets only and saturate at all
// ones.

module clock_replacement_cache #(
   parameter int MAX_SLOTS = ccr_pkg::DEFAULT_MAX_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*ccr_pkg::DATA_W-1:0]      req_tdata,   // key, write_value
   input  logic                              req_tuser,   // req_type
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [3*ccr_pkg::DATA_W-1:0]      rsp_tdata,   // read_value, hit_total,
                                                          // access_total
   output logic                              rsp_tuser,   // hit
   // capacity register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccr_pkg::CAPACITY_W-1:0]    csr_wdata    // capacity
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CAP_W = (CNT_W > ccr_pkg::CAPACITY_W) ? CNT_W : ccr_pkg::CAPACITY_W;
   localparam int DW    = ccr_pkg::DATA_W;

   ccr_pkg::state_type state_ff, state_in;

   logic [ccr_pkg::CAPACITY_W-1:0] capacity_ff;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [IDX_W-1:0]     hand_ff, hand_in;
   logic [MAX_SLOTS-1:0] ref_ff, ref_in;
   logic [DW-1:0]        hit_cnt_ff, hit_cnt_in;
   logic [DW-1:0]        acc_cnt_ff, acc_cnt_in;

   // latched request and lookup result
   logic          req_put_ff, req_put_in;
   logic [DW-1:0] req_key_ff, req_key_in;
   logic [DW-1:0] req_val_ff, req_val_in;
   logic          hit_ff, hit_in;
   logic [DW-1:0] rd_val_ff, rd_val_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [DW-1:0] rsp_rd_ff, rsp_rd_in;

   // RAM and scan hookup
   logic             key_we, val_we;
   logic [IDX_W-1:0] wr_addr;
   logic             scan_start;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] scan_slot;
   logic [DW-1:0]    key_rdata, val_rdata;
   ccr_pkg::scan_status_type scan_status;

   logic             req_xfer;
   logic             rsp_free;
   logic [CNT_W-1:0] eff_cap;
   logic [CNT_W-1:0] eff_m1;
   logic [IDX_W-1:0] hand_step;

   assign req_tready = (state_ff == ccr_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // capacity clamped to the slot count
   assign eff_cap = (CAP_W'(capacity_ff) > CAP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                              : CNT_W'(capacity_ff);
   assign eff_m1  = eff_cap - CNT_W'(1);
   // hand moves downward and wraps from 0 to capacity - 1
   assign hand_step = (hand_ff == '0) ? eff_m1[IDX_W-1:0] : hand_ff - IDX_W'(1);

   ccr_ram #(.WIDTH(DW), .DEPTH(MAX_SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (req_key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rdata)
   );

   ccr_ram #(.WIDTH(DW), .DEPTH(MAX_SLOTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_addr),
      .wr_data (req_val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   ccr_scan #(.MAX_SLOTS(MAX_SLOTS)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .limit     (fill_ff),
      .key       (req_key_ff),
      .key_rdata (key_rdata),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .slot      (scan_slot),
      .status    (scan_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = ccr_pkg::ST_SCAN;
            end
         end
         ccr_pkg::ST_SCAN: begin
            if (scan_status.done) begin
               if (req_put_ff == ccr_pkg::REQ_PUT && !scan_status.hit &&
                   !(fill_ff < eff_cap) && eff_cap != '0) begin
                  state_in = ccr_pkg::ST_SWEEP;
               end else begin
                  state_in = ccr_pkg::ST_FINISH;
               end
            end
         end
         ccr_pkg::ST_SWEEP: begin
            if (!ref_ff[hand_ff]) begin
               state_in = ccr_pkg::ST_FINISH;
            end
         end
         ccr_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = ccr_pkg::ST_IDLE;
            end
         end
         default: state_in = ccr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      scan_start   = 1'b0;
      key_we       = 1'b0;
      val_we       = 1'b0;
      wr_addr      = scan_slot;
      fill_in      = fill_ff;
      hand_in      = hand_ff;
      ref_in       = ref_ff;
      hit_cnt_in   = hit_cnt_ff;
      acc_cnt_in   = acc_cnt_ff;
      req_put_in   = req_put_ff;
      req_key_in   = req_key_ff;
      req_val_in   = req_val_ff;
      hit_in       = hit_ff;
      rd_val_in    = rd_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_rd_in    = rsp_rd_ff;

      unique case (state_ff)
         ccr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               scan_start = 1'b1;
               req_put_in = req_tuser;
               req_key_in = req_tdata[DW-1:0];
               req_val_in = req_tdata[2*DW-1:DW];
            end
         end
         ccr_pkg::ST_SCAN: begin
            if (scan_status.done) begin
               hit_in    = scan_status.hit;
               rd_val_in = '0;
               if (scan_status.hit) begin
                  ref_in[scan_slot] = 1'b1;
                  if (req_put_ff == ccr_pkg::REQ_PUT) begin
                     val_we = 1'b1;
                  end else begin
                     rd_val_in = val_rdata;
                  end
               end else if (req_put_ff == ccr_pkg::REQ_PUT) begin
                  if (fill_ff < eff_cap) begin
                     // still filling: take the next free slot
                     key_we            = 1'b1;
                     val_we            = 1'b1;
                     wr_addr           = fill_ff[IDX_W-1:0];
                     ref_in[wr_addr]   = 1'b1;
                     fill_in           = fill_ff + CNT_W'(1);
                  end else if (eff_cap != '0) begin
                     // hand left beyond a lowered capacity is pulled back
                     if (CNT_W'(hand_ff) >= eff_cap) begin
                        hand_in = eff_m1[IDX_W-1:0];
                     end
                  end
               end
            end
         end
         ccr_pkg::ST_SWEEP: begin
            wr_addr = hand_ff;
            hand_in = hand_step;
            if (!ref_ff[hand_ff]) begin
               key_we          = 1'b1;
               val_we          = 1'b1;
               ref_in[hand_ff] = 1'b1;
            end else begin
               ref_in[hand_ff] = 1'b0;   // second chance
            end
         end
         ccr_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_rd_in    = rd_val_ff;
               if (req_put_ff == ccr_pkg::REQ_GET) begin
                  if (acc_cnt_ff != '1) begin
                     acc_cnt_in = acc_cnt_ff + DW'(1);
                  end
                  if (hit_ff && hit_cnt_ff != '1) begin
                     hit_cnt_in = hit_cnt_ff + DW'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccr_pkg::ST_IDLE;
         capacity_ff  <= ccr_pkg::CAPACITY_RESET;
         fill_ff      <= '0;
         hand_ff      <= '0;
         ref_ff       <= '0;
         hit_cnt_ff   <= '0;
         acc_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_wdata;
         end
         fill_ff      <= fill_in;
         hand_ff      <= hand_in;
         ref_ff       <= ref_in;
         hit_cnt_ff   <= hit_cnt_in;
         acc_cnt_ff   <= acc_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_put_ff <= req_put_in;
      req_key_ff <= req_key_in;
      req_val_ff <= req_val_in;
      hit_ff     <= hit_in;
      rd_val_ff  <= rd_val_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_rd_ff  <= rsp_rd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {acc_cnt_ff, hit_cnt_ff, rsp_rd_ff};

`ifndef NO_ASSERTIONS
   // a response only appears out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ccr_pkg::ST_FINISH))
      else $error("response raised outside finish");

   // the fill count only moves at the end of a lookup
   a_fill_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ccr_pkg::ST_SCAN) |=> $stable(fill_ff))
      else $error("fill count changed outside lookup");

   // the hand stays inside the active slots while sweeping
   a_hand_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ccr_pkg::ST_SWEEP) |-> (CNT_W'(hand_ff) < eff_cap))
      else $error("clock hand beyond capacity");

   // fill count never runs past the slot count
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      CAP_W'(fill_ff) <= CAP_W'(MAX_SLOTS))
      else $error("fill count overflow");
`endif

endmodule
